### rtl/aabb_pkg.sv
`default_nettype none

package aabb_pkg;

  // Q16.16 scalar and its fraction width
  localparam int unsigned DataW = 32;
  localparam int unsigned FracW = 16;

  // Product after the fraction shift, and the three-term sum before saturation
  localparam int unsigned ProdW = 2 * DataW - FracW;
  localparam int unsigned SumW  = ProdW + 2;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgMxx   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgMxy   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgMyx   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgMyy   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgShiftX = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgShiftY = 3'd5;

  // Reset values of the registers
  localparam logic signed [DataW-1:0] OneQ     = 32'sd65536;
  localparam logic signed [DataW-1:0] ZeroQ    = 32'sd0;
  localparam logic signed [DataW-1:0] MaxS32   = 32'sh7fffffff;
  localparam logic signed [DataW-1:0] MinS32   = 32'sh80000000;

  typedef struct packed {
    logic signed [DataW-1:0] vertex_x;
    logic signed [DataW-1:0] vertex_y;
    logic                    last_vertex;
  } vertex_t;

  typedef struct packed {
    logic signed [DataW-1:0] local_min_x;
    logic signed [DataW-1:0] local_min_y;
    logic signed [DataW-1:0] local_max_x;
    logic signed [DataW-1:0] local_max_y;
    logic signed [DataW-1:0] world_min_x;
    logic signed [DataW-1:0] world_min_y;
    logic signed [DataW-1:0] world_max_x;
    logic signed [DataW-1:0] world_max_y;
  } box_t;

  // Local box handed from the accumulator stage to the transform
  typedef struct packed {
    logic signed [DataW-1:0] min_x;
    logic signed [DataW-1:0] min_y;
    logic signed [DataW-1:0] max_x;
    logic signed [DataW-1:0] max_y;
  } lbox_t;

  // Load strobes of the transform stages
  typedef struct packed {
    logic prod_load;
    logic sum_load;
  } pipe_ctrl_t;

  // Clamp a wide sum to the signed 32-bit range
  function automatic logic signed [DataW-1:0] sat32(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] hi;
    logic signed [SumW-1:0] lo;
    hi = SumW'(MaxS32);
    lo = SumW'(MinS32);
    if (v > hi) begin
      sat32 = MaxS32;
    end else if (v < lo) begin
      sat32 = MinS32;
    end else begin
      sat32 = v[DataW-1:0];
    end
  endfunction

endpackage

`default_nettype wire

### rtl/aabb_axis.sv
`default_nettype none

// One world axis: two products picked by coefficient sign, registered, then
// summed with the translation and clamped into the output register.
module aabb_axis (
  input  wire logic                            clk,
  input  wire aabb_pkg::pipe_ctrl_t            ctrl,
  input  wire logic signed [31:0]              coef_x,
  input  wire logic signed [31:0]              coef_y,
  input  wire logic signed [31:0]              offset,
  input  wire aabb_pkg::lbox_t                 lbox,
  output logic signed [31:0]                   world_min,
  output logic signed [31:0]                   world_max
);
  import aabb_pkg::*;

  logic signed [DataW-1:0]   op_x_min, op_x_max, op_y_min, op_y_max;
  logic signed [2*DataW-1:0] mul_x_min, mul_x_max, mul_y_min, mul_y_max;
  logic signed [ProdW-1:0]   px_min, px_max, py_min, py_max;
  logic signed [SumW-1:0]    sum_min, sum_max;

  // Pick the box corner by the sign of each coefficient
  always_comb begin
    if (coef_x > ZeroQ) begin
      op_x_min = lbox.min_x;
      op_x_max = lbox.max_x;
    end else begin
      op_x_min = lbox.max_x;
      op_x_max = lbox.min_x;
    end
    if (coef_y > ZeroQ) begin
      op_y_min = lbox.min_y;
      op_y_max = lbox.max_y;
    end else begin
      op_y_min = lbox.max_y;
      op_y_max = lbox.min_y;
    end
  end

  assign mul_x_min = coef_x * op_x_min;
  assign mul_x_max = coef_x * op_x_max;
  assign mul_y_min = coef_y * op_y_min;
  assign mul_y_max = coef_y * op_y_max;

  // Hold products with the fraction dropped (rounds towards minus infinity)
  always_ff @(posedge clk) begin
    if (ctrl.prod_load) begin
      px_min <= mul_x_min[2*DataW-1:FracW];
      px_max <= mul_x_max[2*DataW-1:FracW];
      py_min <= mul_y_min[2*DataW-1:FracW];
      py_max <= mul_y_max[2*DataW-1:FracW];
    end
  end

  assign sum_min = SumW'(offset) + SumW'(px_min) + SumW'(py_min);
  assign sum_max = SumW'(offset) + SumW'(px_max) + SumW'(py_max);

  // Clamp and register the world bounds
  always_ff @(posedge clk) begin
    if (ctrl.sum_load) begin
      world_min <= sat32(sum_min);
      world_max <= sat32(sum_max);
    end
  end

endmodule

`default_nettype wire

### rtl/aabb_build_and_transform.sv
// Streaming 2D bounding box with affine transform.
// Vertex channel (vertex_valid/vertex_ready/vertex): one signed Q16.16 point
// per transfer, with last_vertex marking the final point of a shape. Every
// vertex is folded into a running per-axis minimum and maximum.
// Box channel (box_valid/box_ready/box): one transfer per shape, carrying the
// local box and the transformed world box, clamped to 32 bits.
// Configuration: cfg_we/cfg_index/cfg_data write one register of the 2x2
// matrix or translation; write only while no shape result is pending.
// Throughput: one vertex per cycle while the output is not stalled, shapes
// back to back with no gap. The local box is registered as the last vertex
// is taken, then passes the product register behind the eight 32x32
// multipliers and the three-term add and clamp into the output register.
// Reset clears all valids, restores the identity transform and empties the
// running box. When the receiver stalls the result holds in the output
// register; the two stages behind it fill, after which vertex_ready drops.
`default_nettype none

module aabb_build_and_transform (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 vertex_valid,
  output logic                                      vertex_ready,
  input  wire aabb_pkg::vertex_t                    vertex,
  output logic                                      box_valid,
  input  wire logic                                 box_ready,
  output aabb_pkg::box_t                            box,
  input  wire logic                                 cfg_we,
  input  wire logic [aabb_pkg::CfgIdxW-1:0]         cfg_index,
  input  wire logic [aabb_pkg::DataW-1:0]           cfg_data
);
  import aabb_pkg::*;

  logic signed [DataW-1:0] m_xx, m_xy, m_yx, m_yy, shift_x, shift_y;
  logic signed [DataW-1:0] run_min_x, run_min_y, run_max_x, run_max_y;
  logic signed [DataW-1:0] min_x_next, min_y_next, max_x_next, max_y_next;
  lbox_t                   acc_box, prod_box, out_box;
  logic                    acc_valid, prod_valid;
  logic                    accept, out_free, prod_free, acc_free;
  pipe_ctrl_t              ctrl;
  logic signed [DataW-1:0] wx_min, wx_max, wy_min, wy_max;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      m_xx    <= OneQ;
      m_xy    <= ZeroQ;
      m_yx    <= ZeroQ;
      m_yy    <= OneQ;
      shift_x <= ZeroQ;
      shift_y <= ZeroQ;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgMxx:    m_xx    <= cfg_data;
        CfgMxy:    m_xy    <= cfg_data;
        CfgMyx:    m_yx    <= cfg_data;
        CfgMyy:    m_yy    <= cfg_data;
        CfgShiftX: shift_x <= cfg_data;
        CfgShiftY: shift_y <= cfg_data;
        default:   ;
      endcase
    end
  end

  // Stage handshakes: each stage loads when its successor can take its item
  assign out_free        = !box_valid || box_ready;
  assign ctrl.sum_load   = prod_valid && out_free;
  assign prod_free       = !prod_valid || ctrl.sum_load;
  assign ctrl.prod_load  = acc_valid && prod_free;
  assign acc_free        = !acc_valid || ctrl.prod_load;
  assign vertex_ready    = acc_free;
  assign accept          = vertex_valid && vertex_ready;

  // Fold the incoming vertex into the running box
  always_comb begin
    min_x_next = (vertex.vertex_x < run_min_x) ? vertex.vertex_x : run_min_x;
    max_x_next = (vertex.vertex_x > run_max_x) ? vertex.vertex_x : run_max_x;
    min_y_next = (vertex.vertex_y < run_min_y) ? vertex.vertex_y : run_min_y;
    max_y_next = (vertex.vertex_y > run_max_y) ? vertex.vertex_y : run_max_y;
  end

  // Running box; empty it once the last vertex has been handed on
  always_ff @(posedge clk) begin
    if (rst) begin
      run_min_x <= MaxS32;
      run_min_y <= MaxS32;
      run_max_x <= MinS32;
      run_max_y <= MinS32;
    end else if (accept) begin
      if (vertex.last_vertex) begin
        run_min_x <= MaxS32;
        run_min_y <= MaxS32;
        run_max_x <= MinS32;
        run_max_y <= MinS32;
      end else begin
        run_min_x <= min_x_next;
        run_min_y <= min_y_next;
        run_max_x <= max_x_next;
        run_max_y <= max_y_next;
      end
    end
  end

  // Accumulator stage: capture the finished local box
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_valid <= 1'b0;
    end else begin
      acc_valid <= (accept && vertex.last_vertex) || (acc_valid && !ctrl.prod_load);
    end
    if (accept && vertex.last_vertex) begin
      acc_box.min_x <= min_x_next;
      acc_box.min_y <= min_y_next;
      acc_box.max_x <= max_x_next;
      acc_box.max_y <= max_y_next;
    end
  end

  // Product stage: carry the local box alongside the products
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctrl.prod_load || (prod_valid && !ctrl.sum_load);
    end
    if (ctrl.prod_load) begin
      prod_box <= acc_box;
    end
  end

  aabb_axis u_axis_x (
    .clk       (clk),
    .ctrl      (ctrl),
    .coef_x    (m_xx),
    .coef_y    (m_xy),
    .offset    (shift_x),
    .lbox      (acc_box),
    .world_min (wx_min),
    .world_max (wx_max)
  );

  aabb_axis u_axis_y (
    .clk       (clk),
    .ctrl      (ctrl),
    .coef_x    (m_yx),
    .coef_y    (m_yy),
    .offset    (shift_y),
    .lbox      (acc_box),
    .world_min (wy_min),
    .world_max (wy_max)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      box_valid <= 1'b0;
    end else if (ctrl.sum_load) begin
      box_valid <= 1'b1;
    end else if (box_ready) begin
      box_valid <= 1'b0;
    end
    if (ctrl.sum_load) begin
      out_box <= prod_box;
    end
  end

  assign box.local_min_x = out_box.min_x;
  assign box.local_min_y = out_box.min_y;
  assign box.local_max_x = out_box.max_x;
  assign box.local_max_y = out_box.max_y;
  assign box.world_min_x = wx_min;
  assign box.world_max_x = wx_max;
  assign box.world_min_y = wy_min;
  assign box.world_max_y = wy_max;

endmodule

`default_nettype wire

### rtl/aabb_checker.sv
`default_nettype none

module aabb_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              box_valid,
  input wire logic              box_ready,
  input wire aabb_pkg::box_t    box
);

  // Hold a stalled result until it is taken
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    box_valid && !box_ready |=> box_valid)
    else $error("box_valid dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    box_valid && !box_ready |=> $stable(box))
    else $error("box changed while stalled");

  // A shape holds at least one vertex, so its local box is never inverted
  a_box_order: assert property (@(posedge clk) disable iff (rst)
    box_valid |-> (box.local_min_x <= box.local_max_x) &&
                  (box.local_min_y <= box.local_max_y))
    else $error("local box inverted");

  // The transform is a monotone map of the box, so world bounds are ordered
  a_world_order: assert property (@(posedge clk) disable iff (rst)
    box_valid |-> (box.world_min_x <= box.world_max_x) &&
                  (box.world_min_y <= box.world_max_y))
    else $error("world box inverted");

  // Nothing is presented straight after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !box_valid)
    else $error("result presented after reset");

endmodule

bind aabb_build_and_transform aabb_checker u_aabb_checker (
  .clk          (clk),
  .rst          (rst),
  .box_valid    (box_valid),
  .box_ready    (box_ready),
  .box          (box)
);

`default_nettype wire

### tb/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import aabb_pkg::*;

  // Indexes that decode to no register; writes there must be dropped
  localparam logic [CfgIdxW-1:0] CfgSpareA = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 3'd7;

  localparam int LongHold = 300;

  typedef logic [7:0][DataW-1:0] box_words_t;

  // A box given in full for a directed row, or left to the transform model
  typedef struct packed {
    logic known;
    box_t b;
  } given_t;

  typedef struct packed {
    vertex_t v;
    logic    known;
    box_t    b;
  } row_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 vertex_valid = 1'b0;
  logic                 vertex_ready;
  vertex_t              vertex = '0;
  logic                 box_valid;
  logic                 box_ready = 1'b0;
  box_t                 box;
  logic                 cfg_we = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index = '0;
  logic [DataW-1:0]     cfg_data = '0;

  // Transform registers as the block should hold them
  logic signed [DataW-1:0] xf_mxx = OneQ;
  logic signed [DataW-1:0] xf_mxy = ZeroQ;
  logic signed [DataW-1:0] xf_myx = ZeroQ;
  logic signed [DataW-1:0] xf_myy = OneQ;
  logic signed [DataW-1:0] xf_sx = ZeroQ;
  logic signed [DataW-1:0] xf_sy = ZeroQ;

  // Running box of the shape in progress
  logic signed [DataW-1:0] span_min_x = MaxS32;
  logic signed [DataW-1:0] span_min_y = MaxS32;
  logic signed [DataW-1:0] span_max_x = MinS32;
  logic signed [DataW-1:0] span_max_y = MinS32;

  box_t   box_queue [$];
  given_t given_q [$];
  int     mismatches = 0;
  bit     gap_on = 1'b0;
  bit     ready_idle_on = 1'b0;
  bit     long_hold_req = 1'b0;

  string box_field [8] = '{"local_min_x", "local_min_y", "local_max_x", "local_max_y",
                           "world_min_x", "world_min_y", "world_max_x", "world_max_y"};

  // Directed shapes, all under the identity transform left by reset
  row_t directed_rows [14] = '{
    // lone vertex at the origin
    '{'{ZeroQ, ZeroQ, 1'b1}, 1'b1, '0},
    // lone vertex at opposite extremes on the two axes
    '{'{MaxS32, MinS32, 1'b1}, 1'b1,
      '{MaxS32, MinS32, MaxS32, MinS32, MaxS32, MinS32, MaxS32, MinS32}},
    // two vertices spanning the whole range
    '{'{MinS32, MaxS32, 1'b0}, 1'b0, '0},
    '{'{MaxS32, MinS32, 1'b1}, 1'b1,
      '{MinS32, MinS32, MaxS32, MaxS32, MinS32, MinS32, MaxS32, MaxS32}},
    // smallest negative step, rounded down stays put
    '{'{-32'sd1, -32'sd1, 1'b1}, 1'b1, '1},
    '{'{32'sh0001_0000, 32'sh0002_0000, 1'b0}, 1'b0, '0},
    '{'{-32'sh0003_0000, 32'sh0000_8000, 1'b0}, 1'b0, '0},
    '{'{32'sd1, -32'sd1, 1'b1}, 1'b0, '0},
    '{'{32'sd5, 32'sd7, 1'b0}, 1'b0, '0},
    '{'{32'sd3, 32'sd9, 1'b0}, 1'b0, '0},
    '{'{32'sd8, 32'sd1, 1'b0}, 1'b0, '0},
    '{'{32'sd4, 32'sd4, 1'b1}, 1'b0, '0},
    '{'{32'sh7fff_0000, 32'sh8001_0000, 1'b1}, 1'b0, '0},
    '{'{-32'sh0000_8000, 32'sh0000_8000, 1'b1}, 1'b0, '0}
  };

  aabb_build_and_transform dut (
    .clk          (clk),
    .rst          (rst),
    .vertex_valid (vertex_valid),
    .vertex_ready (vertex_ready),
    .vertex       (vertex),
    .box_valid    (box_valid),
    .box_ready    (box_ready),
    .box          (box),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Q16.16 product, floored by the fraction shift
  function automatic longint scale_q(input logic signed [DataW-1:0] m,
                                     input logic signed [DataW-1:0] v);
    longint p;
    p = longint'(m) * longint'(v);
    return p >>> FracW;
  endfunction

  function automatic logic signed [DataW-1:0] clamp_q(input longint s);
    if (s > longint'(MaxS32)) return MaxS32;
    if (s < longint'(MinS32)) return MinS32;
    return s[DataW-1:0];
  endfunction

  // Add one matrix term: a positive term keeps min with min, otherwise swap
  task automatic spread_term(input logic signed [DataW-1:0] m, lo, hi,
                             inout longint acc_lo, inout longint acc_hi);
    if (m > 0) begin
      acc_lo += scale_q(m, lo);
      acc_hi += scale_q(m, hi);
    end else begin
      acc_lo += scale_q(m, hi);
      acc_hi += scale_q(m, lo);
    end
  endtask

  // Fold a vertex into the running box; on the last one queue the box
  task automatic fold_vertex(input vertex_t v, input given_t g);
    longint wlo_x, whi_x, wlo_y, whi_y;
    box_t   calc;
    if (v.vertex_x < span_min_x) span_min_x = v.vertex_x;
    if (v.vertex_x > span_max_x) span_max_x = v.vertex_x;
    if (v.vertex_y < span_min_y) span_min_y = v.vertex_y;
    if (v.vertex_y > span_max_y) span_max_y = v.vertex_y;
    if (!v.last_vertex) return;
    wlo_x = xf_sx;
    whi_x = xf_sx;
    wlo_y = xf_sy;
    whi_y = xf_sy;
    spread_term(xf_mxx, span_min_x, span_max_x, wlo_x, whi_x);
    spread_term(xf_mxy, span_min_y, span_max_y, wlo_x, whi_x);
    spread_term(xf_myx, span_min_x, span_max_x, wlo_y, whi_y);
    spread_term(xf_myy, span_min_y, span_max_y, wlo_y, whi_y);
    calc.local_min_x = span_min_x;
    calc.local_min_y = span_min_y;
    calc.local_max_x = span_max_x;
    calc.local_max_y = span_max_y;
    calc.world_min_x = clamp_q(wlo_x);
    calc.world_min_y = clamp_q(wlo_y);
    calc.world_max_x = clamp_q(whi_x);
    calc.world_max_y = clamp_q(whi_y);
    box_queue.push_back(g.known ? g.b : calc);
    span_min_x = MaxS32;
    span_min_y = MaxS32;
    span_max_x = MinS32;
    span_max_y = MinS32;
  endtask

  // Watch every transfer: register writes, boxes out, vertices in
  always @(posedge clk) begin
    box_t       want;
    given_t     g;
    box_words_t want_w;
    box_words_t got_w;
    if (!rst) begin
      if (cfg_we) begin
        case (cfg_index)
          CfgMxx:    xf_mxx = cfg_data;
          CfgMxy:    xf_mxy = cfg_data;
          CfgMyx:    xf_myx = cfg_data;
          CfgMyy:    xf_myy = cfg_data;
          CfgShiftX: xf_sx = cfg_data;
          CfgShiftY: xf_sy = cfg_data;
          default: ;
        endcase
      end
      // check before queueing, so a stray box cannot match a fresh expectation
      if (box_valid && box_ready) begin
        if (box_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("box transfer with none pending: %h", box);
        end else begin
          want = box_queue.pop_front();
          want_w = want;
          got_w = box;
          for (int i = 0; i < 8; i++) begin
            if (got_w[7-i] !== want_w[7-i]) begin
              mismatches++;
              if (mismatches <= 10) begin
                $display("%s: expected %h, got %h", box_field[i], want_w[7-i], got_w[7-i]);
              end
            end
          end
        end
      end
      if (vertex_valid && vertex_ready) begin
        g = given_q.pop_front();
        fold_vertex(vertex, g);
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    wait (!rst);
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        box_ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        long_hold_req = 1'b0;
      end
      if (ready_idle_on && $urandom_range(0, 9) == 0) begin
        box_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      box_ready <= 1'b1;
    end
  end

  function automatic logic signed [DataW-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return MinS32;
      1: return MaxS32;
      2: return ZeroQ;
      3: return OneQ;
      4, 5: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      default: return $urandom();
    endcase
  endfunction

  // Offer one vertex, with an occasional gap ahead of it, and hold until transfer
  task automatic offer_vertex(input vertex_t v, input logic known, input box_t b);
    if (gap_on && $urandom_range(0, 9) == 0) begin
      vertex_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    given_q.push_back('{known, b});
    vertex_valid <= 1'b1;
    vertex <= v;
    do @(posedge clk); while (!vertex_ready);
  endtask

  // Stream whole shapes, mostly short, now and then long
  task automatic run_shapes(input int n_items);
    vertex_t v;
    int      sent;
    int      len;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
      for (int k = 0; k < len; k++) begin
        v.vertex_x = pick_coord();
        v.vertex_y = pick_coord();
        v.last_vertex = (k == len - 1);
        offer_vertex(v, 1'b0, '0);
        sent++;
      end
    end
    vertex_valid <= 1'b0;
  endtask

  // Wait for every pending box, then let the pipeline empty
  task automatic settle_block();
    int waited;
    waited = 0;
    // let the monitor take in the last vertex transfer first
    @(posedge clk);
    while (box_queue.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (6) @(posedge clk);
  endtask

  // Write all six registers, then both spare indexes with junk
  task automatic load_transform(input logic signed [DataW-1:0] mxx, mxy, myx, myy, sx, sy);
    logic [CfgIdxW-1:0] slot [8];
    logic [DataW-1:0]   wdata [8];
    slot = '{CfgMxx, CfgMxy, CfgMyx, CfgMyy, CfgShiftX, CfgShiftY, CfgSpareA, CfgSpareB};
    wdata = '{mxx, mxy, myx, myy, sx, sy, $urandom(), $urandom()};
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= slot[i];
      cfg_data <= wdata[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    gap_on = 1'b1;
    ready_idle_on = 1'b1;

    foreach (directed_rows[i]) begin
      offer_vertex(directed_rows[i].v, directed_rows[i].known, directed_rows[i].b);
    end
    vertex_valid <= 1'b0;

    for (int p = 0; p < 10; p++) begin
      settle_block();
      case (p)
        0: load_transform(MinS32, MinS32, MinS32, MinS32, MaxS32, MinS32);
        1: load_transform(MaxS32, MaxS32, MaxS32, MaxS32, MaxS32, MaxS32);
        2: load_transform(ZeroQ, ZeroQ, ZeroQ, ZeroQ, pick_coord(), pick_coord());
        3: load_transform(32'sd46341, -32'sd46341, 32'sd46341, 32'sd46341,
                          32'sh0010_0000, -32'sh0010_0000);
        4: load_transform(-32'sd65536, ZeroQ, ZeroQ, -32'sd65536, ZeroQ, ZeroQ);
        9: load_transform(OneQ, ZeroQ, ZeroQ, OneQ, ZeroQ, ZeroQ);
        default: load_transform(pick_coord(), pick_coord(), pick_coord(),
                                pick_coord(), pick_coord(), pick_coord());
      endcase
      // no idling on either side towards the end
      gap_on = (p < 8);
      ready_idle_on = (p < 8);
      // hold the output long enough for the block to back up onto its input
      if (p == 2) long_hold_req = 1'b1;
      run_shapes(44);
    end

    settle_block();
    if (box_queue.size() != 0) begin
      mismatches++;
      $display("%0d boxes never arrived", box_queue.size());
    end
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

### aabb_build_and_transform.f
rtl/aabb_pkg.sv
rtl/aabb_axis.sv
rtl/aabb_build_and_transform.sv
rtl/aabb_checker.sv
tb/testbench.sv
